// ===== src/spi_power_manager_registers_macros.svh =====
// Assertion macros shared by the power manager register block.
`ifndef SPI_POWER_MANAGER_REGISTERS_MACROS_SVH
`define SPI_POWER_MANAGER_REGISTERS_MACROS_SVH

`ifndef SYNTHESIS

`define SPM_ASSERT_NOW(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("Power manager assertion failed.");

`define SPM_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("Power manager assertion failed.");

`else

`define SPM_ASSERT_NOW(label, clk, rst, cond, expr)

`define SPM_ASSERT_NEXT(label, clk, rst, cond, expr)

`endif

`endif

// ===== src/spm_pkg.sv =====
// Types and constants of the power manager register block.
package spm_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       chip_select;
      logic       battery_status;
      logic       external_power;
   } req_word_type;

   typedef struct packed {
      logic [7:0] read_byte;
      logic       shutdown;
   } rsp_word_type;

   localparam logic [7:0] CMD_MASK_ORIG = 8'h83;
   localparam logic [7:0] CMD_MASK_LITE = 8'h87;
   localparam logic [6:0] PWR_MASK_ORIG = 7'h7F;
   localparam logic [6:0] PWR_MASK_LITE = 7'h7D;
   localparam int         SHUTDOWN_BIT  = 6;

   localparam logic [7:0] CMD_POWER_WR  = 8'h00;
   localparam logic [7:0] CMD_POWER_RD  = 8'h80;
   localparam logic [7:0] CMD_BATT_RD   = 8'h81;
   localparam logic [7:0] CMD_MIC_EN_WR = 8'h02;
   localparam logic [7:0] CMD_MIC_EN_RD = 8'h82;
   localparam logic [7:0] CMD_GAIN_WR   = 8'h03;
   localparam logic [7:0] CMD_GAIN_RD   = 8'h83;
   localparam logic [7:0] CMD_BL_WR     = 8'h04;
   localparam logic [7:0] CMD_BL_RD     = 8'h84;

   localparam logic [1:0] COUNT_COMMAND = 2'd1;
   localparam logic [1:0] COUNT_MAX     = 2'd2;

endpackage

// ===== src/spm_in_reg.sv =====
// Input register of the power manager register block.
module spm_in_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  spm_pkg::req_word_type req_word,
   input  logic                 out_free,
   output logic                 in_valid,
   output spm_pkg::req_word_type in_word
);

   logic                  valid_ff;
   logic                  valid_in;
   spm_pkg::req_word_type word_ff;
   spm_pkg::req_word_type word_in;
   logic                  accept;

   assign req_stall = valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;
   assign valid_in  = accept || (valid_ff && !out_free);
   assign word_in   = accept ? req_word : word_ff;
   assign in_valid  = valid_ff;
   assign in_word   = word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      word_ff <= word_in;
   end

endmodule

// ===== src/spm_access.sv =====
// Register state, command decode and result register of the power manager.
`include "spi_power_manager_registers_macros.svh"

module spm_access (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  console_model,
   input  logic                  in_valid,
   input  spm_pkg::req_word_type in_word,
   output logic                  out_free,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output spm_pkg::rsp_word_type rsp_word
);

   logic [7:0]            command_ff;
   logic [7:0]            command_in;
   logic [1:0]            count_ff;
   logic [1:0]            count_in;
   logic                  held_ff;
   logic                  held_in;
   logic [6:0]            power_ff;
   logic [6:0]            power_in;
   logic                  mic_en_ff;
   logic                  mic_en_in;
   logic [1:0]            gain_ff;
   logic [1:0]            gain_in;
   logic [2:0]            bl_ff;
   logic [2:0]            bl_in;
   logic                  out_valid_ff;
   logic                  out_valid_in;
   spm_pkg::rsp_word_type out_word_ff;
   spm_pkg::rsp_word_type out_word_in;
   spm_pkg::rsp_word_type result;
   logic                  advance;
   logic [7:0]            cmd;
   logic [3:0]            bl_read;

   assign out_free     = !out_valid_ff || !rsp_stall;
   assign advance      = in_valid && out_free;
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);
   assign out_word_in  = advance ? result : out_word_ff;
   assign rsp_valid    = out_valid_ff;
   assign rsp_word     = out_word_ff;

   always_comb begin
      cmd = command_ff;
      if (console_model && (command_ff[6:2] == 5'b00001)) begin
         cmd = {command_ff[7], 7'h04};
      end
      bl_read = {in_word.external_power, bl_ff};
      if (bl_ff[2] && in_word.external_power) begin
         bl_read[1:0] = 2'b11;
      end
   end

   always_comb begin
      command_in       = command_ff;
      count_in         = count_ff;
      power_in         = power_ff;
      mic_en_in        = mic_en_ff;
      gain_in          = gain_ff;
      bl_in            = bl_ff;
      held_in          = in_word.chip_select;
      result.read_byte = 8'h00;
      result.shutdown  = 1'b0;
      if (!held_ff) begin
         command_in = in_word.data_byte &
            (console_model ? spm_pkg::CMD_MASK_LITE : spm_pkg::CMD_MASK_ORIG);
         count_in = spm_pkg::COUNT_COMMAND;
      end else begin
         if (count_ff == spm_pkg::COUNT_COMMAND) begin
            unique case (cmd)
               spm_pkg::CMD_POWER_WR: begin
                  power_in = in_word.data_byte[6:0] &
                     (console_model ? spm_pkg::PWR_MASK_LITE : spm_pkg::PWR_MASK_ORIG);
                  result.shutdown = in_word.data_byte[spm_pkg::SHUTDOWN_BIT];
               end
               spm_pkg::CMD_POWER_RD:  result.read_byte = {1'b0, power_ff};
               spm_pkg::CMD_BATT_RD:   result.read_byte = {7'b0, in_word.battery_status};
               spm_pkg::CMD_MIC_EN_WR: mic_en_in = in_word.data_byte[0];
               spm_pkg::CMD_MIC_EN_RD: result.read_byte = {7'b0, mic_en_ff};
               spm_pkg::CMD_GAIN_WR:   gain_in = in_word.data_byte[1:0];
               spm_pkg::CMD_GAIN_RD:   result.read_byte = {6'b0, gain_ff};
               spm_pkg::CMD_BL_WR:     bl_in = in_word.data_byte[2:0];
               spm_pkg::CMD_BL_RD:     result.read_byte = {4'b0, bl_read};
               default: ;
            endcase
         end
         if (count_ff < spm_pkg::COUNT_MAX) begin
            count_in = count_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         command_ff   <= 8'h00;
         count_ff     <= 2'd0;
         held_ff      <= 1'b0;
         power_ff     <= 7'h00;
         mic_en_ff    <= 1'b0;
         gain_ff      <= 2'd0;
         bl_ff        <= 3'd0;
         out_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            command_ff <= command_in;
            count_ff   <= count_in;
            held_ff    <= held_in;
            power_ff   <= power_in;
            mic_en_ff  <= mic_en_in;
            gain_ff    <= gain_in;
            bl_ff      <= bl_in;
         end
         out_valid_ff <= out_valid_in;
      end
      out_word_ff <= out_word_in;
   end

   `SPM_ASSERT_NOW(a_count_saturates, clock, reset, 1'b1, count_ff <= spm_pkg::COUNT_MAX)
   `SPM_ASSERT_NOW(a_held_has_command, clock, reset, held_ff, count_ff != 2'd0)
   `SPM_ASSERT_NOW(a_shutdown_no_data, clock, reset, out_valid_ff && out_word_ff.shutdown,
      out_word_ff.read_byte == 8'h00)
   `SPM_ASSERT_NEXT(a_advance_fills, clock, reset, advance, out_valid_ff)

endmodule

// ===== src/spi_power_manager_registers.sv =====
// Top level of the power manager register block on a byte-serial bus.
// Each word is one bus byte and gives one result word. An accepted word is registered in the
// input register, then decoded in the access stage, and its result word is registered in the result register;
// one word is accepted every cycle unless a stalled response holds the result register.
module spi_power_manager_registers (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  spm_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output spm_pkg::rsp_word_type rsp_word,
   input  logic                  csr_write_enable,
   input  logic                  csr_write_data
);

   logic                  console_model_ff;
   logic                  console_model_in;
   logic                  out_free;
   logic                  in_valid;
   spm_pkg::req_word_type in_word;

   assign console_model_in = csr_write_enable ? csr_write_data : console_model_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         console_model_ff <= 1'b0;
      end else begin
         console_model_ff <= console_model_in;
      end
   end

   spm_in_reg u_in_reg (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .out_free  (out_free),
      .in_valid  (in_valid),
      .in_word   (in_word)
   );

   spm_access u_access (
      .clock         (clock),
      .reset         (reset),
      .console_model (console_model_ff),
      .in_valid      (in_valid),
      .in_word       (in_word),
      .out_free      (out_free),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_word      (rsp_word)
   );

endmodule
